// ===== hw/rtl/lprc_pkg.sv =====
package lprc_pkg;

   localparam int CFG_BITS    = 16;
   localparam int INDEX_BITS  = 2;
   localparam int KIND_BITS   = 3;
   localparam int PHASE_BITS  = 2;
   localparam int ELAPSED_BITS = 16;
   localparam int THRESH_SQ_BITS = 2 * CFG_BITS;

   localparam logic [INDEX_BITS-1:0] CSR_ARM_TICKS      = 2'd0;
   localparam logic [INDEX_BITS-1:0] CSR_ANIM_TICKS     = 2'd1;
   localparam logic [INDEX_BITS-1:0] CSR_MOVE_THRESHOLD = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_TICK  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_X     = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_Y     = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_DOWN  = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_UP    = 3'd4;

   localparam logic [PHASE_BITS-1:0] PHASE_IDLE     = 2'd0;
   localparam logic [PHASE_BITS-1:0] PHASE_HOLDING  = 2'd1;
   localparam logic [PHASE_BITS-1:0] PHASE_ARMED    = 2'd2;
   localparam logic [PHASE_BITS-1:0] PHASE_COMPLETE = 2'd3;

   localparam logic [CFG_BITS-1:0]       ARM_TICKS_RESET  = 16'd300;
   localparam logic [CFG_BITS-1:0]       ANIM_TICKS_RESET = 16'd300;
   localparam logic [THRESH_SQ_BITS-1:0] THRESH_SQ_RESET  = 32'd324;

   typedef struct packed {
      logic [CFG_BITS-1:0]       arm_ticks;
      logic [CFG_BITS-1:0]       anim_ticks;
      logic [THRESH_SQ_BITS-1:0] thresh_sq;
   } cfg_type;

   typedef struct packed {
      logic                    click;
      logic [PHASE_BITS-1:0]   phase;
      logic [ELAPSED_BITS-1:0] anim_elapsed;
      logic                    anchor_moved;
   } rsp_type;

endpackage

// ===== hw/rtl/lprc_csr.sv =====
module lprc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [lprc_pkg::INDEX_BITS-1:0]     csr_index,
   input  logic [lprc_pkg::CFG_BITS-1:0]       csr_wdata,
   output lprc_pkg::cfg_type                   cfg
);

   // The threshold is kept only as its square, worked out when it is written.
   lprc_pkg::cfg_type cfg_ff;
   lprc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            lprc_pkg::CSR_ARM_TICKS: begin
               cfg_in.arm_ticks = csr_wdata;
            end
            lprc_pkg::CSR_ANIM_TICKS: begin
               cfg_in.anim_ticks = csr_wdata;
            end
            lprc_pkg::CSR_MOVE_THRESHOLD: begin
               cfg_in.thresh_sq = lprc_pkg::THRESH_SQ_BITS'(csr_wdata)
                                * lprc_pkg::THRESH_SQ_BITS'(csr_wdata);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arm_ticks  <= lprc_pkg::ARM_TICKS_RESET;
         cfg_ff.anim_ticks <= lprc_pkg::ANIM_TICKS_RESET;
         cfg_ff.thresh_sq  <= lprc_pkg::THRESH_SQ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/lprc_step.sv =====
module lprc_step #(
   parameter int COORD_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic [lprc_pkg::KIND_BITS-1:0]    kind,
   input  logic [lprc_pkg::CFG_BITS-1:0]     coord,
   input  lprc_pkg::cfg_type                 cfg,
   output lprc_pkg::rsp_type                 rsp
);

   localparam int CW = (COORD_BITS > lprc_pkg::CFG_BITS) ? COORD_BITS : lprc_pkg::CFG_BITS;
   localparam int NW = (COUNT_BITS > lprc_pkg::CFG_BITS) ? COUNT_BITS : lprc_pkg::CFG_BITS;
   localparam int QW = 2 * COORD_BITS;
   localparam int SW = (QW + 1 > lprc_pkg::THRESH_SQ_BITS) ? QW + 1
                                                          : lprc_pkg::THRESH_SQ_BITS;
   localparam logic [CW-1:0]         COORD_LIMIT = CW'({COORD_BITS{1'b1}});
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

   logic                  down_ff, down_in;
   logic                  armed_ff, armed_in;
   logic                  complete_ff, complete_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0] origin_y_ff, origin_y_in;
   logic [COUNT_BITS-1:0] hold_ff, hold_in;
   logic [COUNT_BITS-1:0] anim_ff, anim_in;

   logic [CW-1:0]         coord_wide;
   logic [COORD_BITS-1:0] coord_clamp;
   logic [COORD_BITS-1:0] new_x, new_y;
   logic [COORD_BITS-1:0] dx, dy;
   logic [QW-1:0]         sx, sy;
   logic [SW-1:0]         dist_sq;
   logic                  too_far;
   logic [COUNT_BITS-1:0] hold_inc, anim_inc, anim_step;
   logic                  click, moved;
   logic [NW-1:0]         anim_wide;

   assign coord_wide  = CW'(coord);
   assign coord_clamp = (coord_wide > COORD_LIMIT) ? COORD_LIMIT[COORD_BITS-1:0]
                                                   : coord_wide[COORD_BITS-1:0];

   // Distance is taken against the position as it stands after this item.
   assign new_x = (kind == lprc_pkg::KIND_X) ? coord_clamp : pos_x_ff;
   assign new_y = (kind == lprc_pkg::KIND_Y) ? coord_clamp : pos_y_ff;
   assign dx = (origin_x_ff > new_x) ? origin_x_ff - new_x : new_x - origin_x_ff;
   assign dy = (origin_y_ff > new_y) ? origin_y_ff - new_y : new_y - origin_y_ff;
   assign sx = QW'(dx) * QW'(dx);
   assign sy = QW'(dy) * QW'(dy);
   assign dist_sq = SW'(sx) + SW'(sy);
   assign too_far = dist_sq > SW'(cfg.thresh_sq);

   assign hold_inc  = (hold_ff == COUNT_MAX) ? hold_ff : hold_ff + 1'b1;
   assign anim_inc  = (anim_ff == COUNT_MAX) ? anim_ff : anim_ff + 1'b1;
   assign anim_step = (NW'(anim_ff) < NW'(cfg.anim_ticks)) ? anim_inc : anim_ff;

   always_comb begin
      down_in     = down_ff;
      armed_in    = armed_ff;
      complete_in = complete_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      hold_in     = hold_ff;
      anim_in     = anim_ff;
      click       = 1'b0;
      moved       = 1'b0;
      unique case (kind) inside
         lprc_pkg::KIND_TICK: begin
            if (down_ff) begin
               if (!armed_ff) begin
                  hold_in = hold_inc;
                  if (NW'(hold_inc) >= NW'(cfg.arm_ticks)) begin
                     armed_in = 1'b1;
                     anim_in  = '0;
                     if (cfg.anim_ticks == '0) begin
                        complete_in = 1'b1;
                     end
                  end
               end else begin
                  anim_in = anim_step;
                  if (NW'(anim_step) >= NW'(cfg.anim_ticks)) begin
                     complete_in = 1'b1;
                  end
               end
            end
         end
         lprc_pkg::KIND_X, lprc_pkg::KIND_Y: begin
            pos_x_in = new_x;
            pos_y_in = new_y;
            if (down_ff && !armed_ff && too_far) begin
               origin_x_in = new_x;
               origin_y_in = new_y;
               hold_in     = '0;
               moved       = 1'b1;
            end
         end
         lprc_pkg::KIND_DOWN: begin
            down_in     = 1'b1;
            armed_in    = 1'b0;
            complete_in = 1'b0;
            hold_in     = '0;
            anim_in     = '0;
            origin_x_in = pos_x_ff;
            origin_y_in = pos_y_ff;
         end
         lprc_pkg::KIND_UP: begin
            click       = complete_ff;
            down_in     = 1'b0;
            armed_in    = 1'b0;
            complete_in = 1'b0;
            hold_in     = '0;
            anim_in     = '0;
         end
         default: begin
            click = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff     <= 1'b0;
         armed_ff    <= 1'b0;
         complete_ff <= 1'b0;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         hold_ff     <= '0;
         anim_ff     <= '0;
      end else if (step_en) begin
         down_ff     <= down_in;
         armed_ff    <= armed_in;
         complete_ff <= complete_in;
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         hold_ff     <= hold_in;
         anim_ff     <= anim_in;
      end
   end

   assign anim_wide = armed_in ? NW'(anim_in) : '0;

   always_comb begin
      rsp.click        = click;
      rsp.anchor_moved = moved;
      rsp.anim_elapsed = anim_wide[lprc_pkg::ELAPSED_BITS-1:0];
      if (!down_in) begin
         rsp.phase = lprc_pkg::PHASE_IDLE;
      end else if (complete_in) begin
         rsp.phase = lprc_pkg::PHASE_COMPLETE;
      end else if (armed_in) begin
         rsp.phase = lprc_pkg::PHASE_ARMED;
      end else begin
         rsp.phase = lprc_pkg::PHASE_HOLDING;
      end
   end

endmodule

// ===== hw/rtl/long_press_right_click_detector_unit.sv =====
// Long-press detector: a touch held still for arm_ticks ticks arms, anim_ticks
// ticks later it is complete, and a touch up on a complete press gives a
// click in its result. Every transaction on the request channel gives exactly
// one result transaction. A request is taken every cycle while results are not
// stalled; each passes an input register, the state update and a result
// register, and its result is presented from the result register. A stalled
// result holds the input register, which then stalls the request channel.
// The threshold square is computed when move_threshold is written, so the
// distance test needs only the two coordinate squares, one add and one
// compare in the state update.
module long_press_right_click_detector_unit #(
   parameter int COORD_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lprc_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [lprc_pkg::CFG_BITS-1:0]       req_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_click,
   output logic [lprc_pkg::PHASE_BITS-1:0]     rsp_phase,
   output logic [lprc_pkg::ELAPSED_BITS-1:0]   rsp_anim_elapsed,
   output logic                                rsp_anchor_moved,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lprc_pkg::INDEX_BITS-1:0]     csr_index,
   input  logic [lprc_pkg::CFG_BITS-1:0]       csr_wdata
);

   logic                               item_valid_ff, item_valid_in;
   logic [lprc_pkg::KIND_BITS-1:0]     kind_ff;
   logic [lprc_pkg::CFG_BITS-1:0]      coord_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   lprc_pkg::rsp_type                  rsp_ff;
   lprc_pkg::rsp_type                  step_rsp;
   lprc_pkg::cfg_type                  cfg;
   logic                               take;
   logic                               advance;

   assign csr_ready = 1'b1;
   assign advance   = item_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   lprc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lprc_step #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .kind    (kind_ff),
      .coord   (coord_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   always_comb begin
      if (take) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff  <= req_kind;
         coord_ff <= req_coord;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_click        = rsp_ff.click;
   assign rsp_phase        = rsp_ff.phase;
   assign rsp_anim_elapsed = rsp_ff.anim_elapsed;
   assign rsp_anchor_moved = rsp_ff.anchor_moved;

endmodule

// ===== bench/long_press_right_click_detector_unit_tb.sv =====
module long_press_right_click_detector_unit_tb;
   import lprc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CFG_BITS-1:0] COORD_TOP = {CFG_BITS{1'b1}};

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [KIND_BITS-1:0]    req_kind;
   logic [CFG_BITS-1:0]     req_coord;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_click;
   logic [PHASE_BITS-1:0]   rsp_phase;
   logic [ELAPSED_BITS-1:0] rsp_anim_elapsed;
   logic                    rsp_anchor_moved;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [INDEX_BITS-1:0]   csr_index;
   logic [CFG_BITS-1:0]     csr_wdata;

   logic [CFG_BITS-1:0] cfg_arm;
   logic [CFG_BITS-1:0] cfg_anim;
   logic [CFG_BITS-1:0] cfg_thr;
   logic                touching;
   logic                armed;
   logic                complete;
   logic [CFG_BITS-1:0] pos_x;
   logic [CFG_BITS-1:0] pos_y;
   logic [CFG_BITS-1:0] origin_x;
   logic [CFG_BITS-1:0] origin_y;
   logic [CFG_BITS-1:0] hold_ticks;
   logic [CFG_BITS-1:0] anim_ticks_seen;

   rsp_type gesture_reports[$];
   int      errors = 0;
   int      sent_count = 0;
   int      burst_left = 0;
   int      cycle_count = 0;

   long_press_right_click_detector_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_coord        (req_coord),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_click        (rsp_click),
      .rsp_phase        (rsp_phase),
      .rsp_anim_elapsed (rsp_anim_elapsed),
      .rsp_anchor_moved (rsp_anchor_moved),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic bit beyond_threshold();
      longint unsigned dx, dy;
      dx = 64'((origin_x > pos_x) ? origin_x - pos_x : pos_x - origin_x);
      dy = 64'((origin_y > pos_y) ? origin_y - pos_y : pos_y - origin_y);
      return (dx * dx + dy * dy) > (longint'(cfg_thr) * longint'(cfg_thr));
   endfunction

   function automatic rsp_type track_gesture(input logic [KIND_BITS-1:0] kind,
                                             input logic [CFG_BITS-1:0] coord);
      rsp_type r;
      r = '0;
      case (kind) inside
         KIND_TICK: begin
            if (touching && !armed) begin
               if (hold_ticks != COORD_TOP) hold_ticks++;
               if (hold_ticks >= cfg_arm) begin
                  armed = 1'b1;
                  anim_ticks_seen = '0;
                  if (cfg_anim == 0) complete = 1'b1;
               end
            end else if (touching) begin
               if (anim_ticks_seen < cfg_anim) anim_ticks_seen++;
               if (anim_ticks_seen >= cfg_anim) complete = 1'b1;
            end
         end
         KIND_X, KIND_Y: begin
            if (kind == KIND_X) pos_x = coord;
            else pos_y = coord;
            if (touching && !armed && beyond_threshold()) begin
               origin_x = pos_x;
               origin_y = pos_y;
               hold_ticks = '0;
               r.anchor_moved = 1'b1;
            end
         end
         KIND_DOWN: begin
            touching = 1'b1;
            armed = 1'b0;
            complete = 1'b0;
            hold_ticks = '0;
            anim_ticks_seen = '0;
            origin_x = pos_x;
            origin_y = pos_y;
         end
         KIND_UP: begin
            r.click = complete;
            touching = 1'b0;
            armed = 1'b0;
            complete = 1'b0;
            hold_ticks = '0;
            anim_ticks_seen = '0;
         end
         default: ;
      endcase
      if (!touching) r.phase = PHASE_IDLE;
      else if (complete) r.phase = PHASE_COMPLETE;
      else if (armed) r.phase = PHASE_ARMED;
      else r.phase = PHASE_HOLDING;
      r.anim_elapsed = armed ? anim_ticks_seen : '0;
      return r;
   endfunction

   function automatic logic [CFG_BITS-1:0] near_coord(input logic [CFG_BITS-1:0] base);
      int span, v;
      span = (cfg_thr > 200) ? 200 : int'(cfg_thr) + 3;
      v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      else if (v > int'(COORD_TOP)) v = int'(COORD_TOP);
      return v[CFG_BITS-1:0];
   endfunction

   task automatic send_event(input logic [KIND_BITS-1:0] kind,
                             input logic [CFG_BITS-1:0] coord);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_coord <= coord;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      gesture_reports.push_back(track_gesture(kind, coord));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (gesture_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_config(input logic [CFG_BITS-1:0] arm,
                               input logic [CFG_BITS-1:0] anim,
                               input logic [CFG_BITS-1:0] thr);
      logic [INDEX_BITS-1:0] idx [3];
      logic [CFG_BITS-1:0]   values [3];
      idx[0] = CSR_ARM_TICKS;
      idx[1] = CSR_ANIM_TICKS;
      idx[2] = CSR_MOVE_THRESHOLD;
      values[0] = arm;
      values[1] = anim;
      values[2] = thr;
      wait_idle();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= values[i];
         @(posedge clock);
         while (csr_ready !== 1'b1) @(posedge clock);
         case (idx[i])
            CSR_ARM_TICKS:  cfg_arm = values[i];
            CSR_ANIM_TICKS: cfg_anim = values[i];
            default:        cfg_thr = values[i];
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_anchor_moves();
      send_event(KIND_DOWN, '0);
      send_event(KIND_X, 16'd18);
      send_event(KIND_Y, 16'd1);
      send_event(KIND_TICK, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_UP, '0);
   endtask

   task automatic test_idle_and_unused();
      for (int k = int'(KIND_UP) + 1; k < (1 << KIND_BITS); k++)
         send_event(k[KIND_BITS-1:0], COORD_TOP);
      send_event(KIND_TICK, COORD_TOP);
      send_event(KIND_X, COORD_TOP);
      send_event(KIND_Y, '0);
   endtask

   task automatic test_short_counts();
      write_config('0, '0, 16'd18);
      send_event(KIND_X, '0);
      send_event(KIND_Y, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_TICK, '0);
      send_event(KIND_X, COORD_TOP);
      send_event(KIND_UP, '0);
      write_config(16'd2, 16'd1, 16'd18);
      send_event(KIND_DOWN, '0);
      repeat (4) send_event(KIND_TICK, '0);
      send_event(KIND_UP, '0);
   endtask

   task automatic test_threshold_extremes();
      write_config(16'd1, 16'd1, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_X, '0);
      send_event(KIND_X, 16'd1);
      send_event(KIND_UP, '0);
      write_config(COORD_TOP, COORD_TOP, COORD_TOP);
      send_event(KIND_X, '0);
      send_event(KIND_Y, '0);
      send_event(KIND_DOWN, '0);
      send_event(KIND_X, COORD_TOP);
      send_event(KIND_Y, COORD_TOP);
      repeat (2) send_event(KIND_TICK, '0);
      send_event(KIND_UP, '0);
   endtask

   task automatic run_random_gestures(input int n_items);
      int target, n_ticks;
      target = sent_count + n_items;
      while (sent_count < target) begin
         if ($urandom_range(0, 99) < 10) begin
            send_event(KIND_BITS'($urandom_range(0, (1 << KIND_BITS) - 1)),
                       CFG_BITS'($urandom));
         end else begin
            if ($urandom_range(0, 3) != 0) begin
               send_event(KIND_X, CFG_BITS'($urandom));
               send_event(KIND_Y, CFG_BITS'($urandom));
            end
            send_event(KIND_DOWN, CFG_BITS'($urandom));
            n_ticks = $urandom_range(0, int'(cfg_arm) + int'(cfg_anim) + 4);
            for (int i = 0; i < n_ticks; i++) begin
               case ($urandom_range(0, 9))
                  0:       send_event(KIND_X, near_coord(origin_x));
                  1:       send_event(KIND_Y, near_coord(origin_y));
                  2:       send_event(KIND_BITS'($urandom_range(int'(KIND_X), int'(KIND_Y))),
                                      CFG_BITS'($urandom));
                  default: send_event(KIND_TICK, CFG_BITS'($urandom));
               endcase
            end
            if ($urandom_range(0, 99) < 85) send_event(KIND_UP, CFG_BITS'($urandom));
         end
      end
   endtask

   task automatic test_random();
      for (int p = 0; p < 6; p++) begin
         case (p % 3)
            0: write_config(CFG_BITS'($urandom_range(0, 12)), CFG_BITS'($urandom_range(0, 12)),
                            CFG_BITS'($urandom_range(0, 40)));
            1: write_config(CFG_BITS'($urandom_range(0, 6)), CFG_BITS'($urandom_range(0, 6)),
                            (p == 1) ? '0 : COORD_TOP);
            default: write_config(CFG_BITS'($urandom_range(0, 12)),
                                  CFG_BITS'($urandom_range(0, 12)), CFG_BITS'($urandom));
         endcase
         run_random_gestures(130);
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         int mode, left;
         mode = $urandom_range(0, 3);
         left = $urandom_range(32, 256);
         while (left > 0) begin
            @(negedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (left % 5 < 2);
            endcase
            left--;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (gesture_reports.size() == 0) begin
            $display("%0t: unexpected result transaction, phase %0h", $time, rsp_phase);
            errors++;
         end else begin
            want = gesture_reports.pop_front();
            if (rsp_click !== want.click) begin
               $display("%0t: click expected %0h, actual %0h", $time, want.click, rsp_click);
               errors++;
            end
            if (rsp_phase !== want.phase) begin
               $display("%0t: phase expected %0h, actual %0h", $time, want.phase, rsp_phase);
               errors++;
            end
            if (rsp_anim_elapsed !== want.anim_elapsed) begin
               $display("%0t: anim_elapsed expected %0h, actual %0h", $time,
                        want.anim_elapsed, rsp_anim_elapsed);
               errors++;
            end
            if (rsp_anchor_moved !== want.anchor_moved) begin
               $display("%0t: anchor_moved expected %0h, actual %0h", $time,
                        want.anchor_moved, rsp_anchor_moved);
               errors++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_TICK;
      req_coord = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ARM_TICKS;
      csr_wdata = '0;
      cfg_arm = ARM_TICKS_RESET;
      cfg_anim = ANIM_TICKS_RESET;
      cfg_thr = 16'd18;
      touching = 1'b0;
      armed = 1'b0;
      complete = 1'b0;
      pos_x = '0;
      pos_y = '0;
      origin_x = '0;
      origin_y = '0;
      hold_ticks = '0;
      anim_ticks_seen = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_anchor_moves();
      test_idle_and_unused();
      test_short_counts();
      test_threshold_extremes();
      test_random();

      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
